>>> rtl/kste_pkg.sv
package kste_pkg;

  localparam int unsigned DIGITS  = 6;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned HOURS_W = 5;
  localparam int unsigned MS_W    = 6;

  localparam logic [6:0] MAX_HOURS  = 7'd23;
  localparam logic [6:0] MAX_MINSEC = 7'd59;

  localparam logic [3:0] COLS_IDLE = 4'hF;

  localparam logic [3:0] KEY_A    = 4'd3;
  localparam logic [3:0] KEY_B    = 4'd7;
  localparam logic [3:0] KEY_C    = 4'd11;
  localparam logic [3:0] KEY_STAR = 4'd12;
  localparam logic [3:0] KEY_ZERO = 4'd13;
  localparam logic [3:0] KEY_HASH = 4'd14;
  localparam logic [3:0] KEY_D    = 4'd15;

  localparam logic [1:0] BEEP_NONE = 2'd0;
  localparam logic [1:0] BEEP_ACK  = 2'd1;
  localparam logic [1:0] BEEP_OK   = 2'd2;
  localparam logic [1:0] BEEP_BAD  = 2'd3;

  localparam logic [1:0] TGT_NONE  = 2'd0;
  localparam logic [1:0] TGT_CLOCK = 2'd1;
  localparam logic [1:0] TGT_ALARM = 2'd2;

  localparam logic [1:0] MODE_CODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_CODE_TIME   = 2'd1;
  localparam logic [1:0] MODE_CODE_ALARM  = 2'd2;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'b001,
    MODE_TIME   = 3'b010,
    MODE_ALARM  = 3'b100
  } mode_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] code;
    logic       sounding;
  } key_evt_t;

  typedef struct packed {
    logic [1:0]         beeps;
    logic [1:0]         target;
    logic [HOURS_W-1:0] hours;
    logic [MS_W-1:0]    minutes;
    logic [MS_W-1:0]    seconds;
    logic               alarm_on;
    logic               stop;
    logic [1:0]         mode;
    logic [CNT_W-1:0]   count;
  } entry_res_t;

  // {is_digit, value}
  function automatic logic [4:0] digit_of(input logic [3:0] code);
    logic [1:0] r;
    logic [1:0] c;
    logic [3:0] v;
    r = code[3:2];
    c = code[1:0];
    v = 4'({2'b00, r} * 4'd3) + {2'b00, c} + 4'd1;
    if (code == KEY_ZERO) begin
      digit_of = 5'b1_0000;
    end else if (r != 2'd3 && c != 2'd3) begin
      digit_of = {1'b1, v};
    end else begin
      digit_of = 5'b0_0000;
    end
  endfunction

  function automatic logic [6:0] two_digits(input logic [3:0] tens, input logic [3:0] ones);
    two_digits = 7'({3'b000, tens} * 7'd10) + {3'b000, ones};
  endfunction

  function automatic logic [1:0] mode_code(input mode_t m);
    case (m)
      MODE_NORMAL: mode_code = MODE_CODE_NORMAL;
      MODE_TIME:   mode_code = MODE_CODE_TIME;
      MODE_ALARM:  mode_code = MODE_CODE_ALARM;
      default:     mode_code = MODE_CODE_NORMAL;
    endcase
  endfunction

endpackage

>>> rtl/keypad_scan_time_entry.sv
// 4x4 keypad scanner with a time-entry front end.
// Input channel (in_valid/in_ready): one beat per scan tick carrying the
// active-low column levels and the buzzer ringing flag.
// Output channel (out_valid/out_ready): exactly one result beat per input
// beat, in order: the row to drive until the next tick, the accepted key if
// any, beep count, a clock or alarm write with its time, alarm enable, buzzer
// stop, entry mode and buffer fill.
// The result is in the output register in the cycle after the input beat is
// taken. One tick per cycle while out_ready is high; all key decoding and the
// entry mode machine settle in a single combinational pass into that register.
// in_ready is high whenever the output register is empty or being drained in
// the same cycle, so a stalled receiver holds the result and back-pressures
// the input; no beat is dropped or repeated.
// Reset (rst, synchronous): row counters and lock clear, normal mode, empty
// digit buffer, alarm disabled, output register empty.
module keypad_scan_time_entry (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [3:0] columns,
  input  logic       alarm_sounding,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] row_drive,
  output logic       key_valid,
  output logic [3:0] key_code,
  output logic [1:0] beeps,
  output logic [1:0] write_target,
  output logic [4:0] set_hours,
  output logic [5:0] set_minutes,
  output logic [5:0] set_seconds,
  output logic       alarm_on,
  output logic       stop_buzzer,
  output logic [1:0] entry_mode,
  output logic [2:0] digits_entered
);

  logic [1:0] scan_row;
  logic [1:0] driven_row;
  logic       key_lock;
  logic       accept;
  logic [1:0] col;

  kste_pkg::key_evt_t   key;
  kste_pkg::entry_res_t res;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // lowest pressed column, column three when none of the first three is low
  always_comb begin
    if (!columns[0]) col = 2'd0;
    else if (!columns[1]) col = 2'd1;
    else if (!columns[2]) col = 2'd2;
    else col = 2'd3;
  end

  assign key.hit      = !key_lock && (columns != kste_pkg::COLS_IDLE);
  assign key.code     = key.hit ? {driven_row, col} : 4'd0;
  assign key.sounding = alarm_sounding;

  kste_entry u_entry (
    .clk  (clk),
    .rst  (rst),
    .step (accept),
    .key  (key),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_row   <= '0;
      driven_row <= '0;
      key_lock   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        // hold the lock while any column is low, release on an all-high tick
        key_lock   <= (columns != kste_pkg::COLS_IDLE);
        driven_row <= scan_row;
        scan_row   <= scan_row + 2'd1;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row_drive      <= scan_row;
      key_valid      <= key.hit;
      key_code       <= key.code;
      beeps          <= res.beeps;
      write_target   <= res.target;
      set_hours      <= res.hours;
      set_minutes    <= res.minutes;
      set_seconds    <= res.seconds;
      alarm_on       <= res.alarm_on;
      stop_buzzer    <= res.stop;
      entry_mode     <= res.mode;
      digits_entered <= res.count;
    end
  end

`ifndef NO_ASSERTIONS
  a_lock_after_key: assert property (@(posedge clk) disable iff (rst)
    (accept && key.hit) |=> key_lock)
    else $error("key accepted without setting the lock");

  a_row_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> (scan_row == row_drive + 2'd1) && (driven_row == row_drive))
    else $error("row counter out of step with the driven row");

  a_write_success: assert property (@(posedge clk) disable iff (rst)
    (out_valid && write_target != kste_pkg::TGT_NONE) |->
      (beeps == kste_pkg::BEEP_OK && entry_mode == kste_pkg::MODE_CODE_NORMAL &&
       digits_entered == 3'd0))
    else $error("time write without success status");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (digits_entered <= 3'd6))
    else $error("digit buffer overfilled");
`endif

endmodule

>>> rtl/kste_entry.sv
module kste_entry (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  kste_pkg::key_evt_t    key,
  output kste_pkg::entry_res_t  res
);

  kste_pkg::mode_t               mode, mode_next;
  logic [3:0]                    digit_buf [kste_pkg::DIGITS];
  logic [3:0]                    digit_buf_next [kste_pkg::DIGITS];
  logic [kste_pkg::CNT_W-1:0]    count, count_next;
  logic                          alarm_en, alarm_en_next;

  logic [4:0] dig;
  logic [6:0] hh, mm, ss;
  logic       time_ok;

  assign dig     = kste_pkg::digit_of(key.code);
  assign hh      = kste_pkg::two_digits(digit_buf[0], digit_buf[1]);
  assign mm      = kste_pkg::two_digits(digit_buf[2], digit_buf[3]);
  assign ss      = kste_pkg::two_digits(digit_buf[4], digit_buf[5]);
  assign time_ok = (hh <= kste_pkg::MAX_HOURS) && (mm <= kste_pkg::MAX_MINSEC) &&
                   (ss <= kste_pkg::MAX_MINSEC);

  always_comb begin
    mode_next     = mode;
    count_next    = count;
    alarm_en_next = alarm_en;
    for (int i = 0; i < kste_pkg::DIGITS; i++) begin
      digit_buf_next[i] = digit_buf[i];
    end
    res         = '0;
    res.beeps   = kste_pkg::BEEP_NONE;
    res.target  = kste_pkg::TGT_NONE;

    if (key.hit) begin
      if (mode == kste_pkg::MODE_NORMAL) begin
        if (key.code == kste_pkg::KEY_A || key.code == kste_pkg::KEY_B) begin
          mode_next  = (key.code == kste_pkg::KEY_A) ? kste_pkg::MODE_TIME
                                                     : kste_pkg::MODE_ALARM;
          count_next = '0;
          for (int i = 0; i < kste_pkg::DIGITS; i++) digit_buf_next[i] = '0;
          res.beeps  = kste_pkg::BEEP_ACK;
        end else if (key.code == kste_pkg::KEY_HASH) begin
          res.stop      = !alarm_en && key.sounding;
          alarm_en_next = !alarm_en;
          res.beeps     = kste_pkg::BEEP_ACK;
        end
      end else if (key.code == kste_pkg::KEY_C) begin
        mode_next  = kste_pkg::MODE_NORMAL;
        count_next = '0;
        for (int i = 0; i < kste_pkg::DIGITS; i++) digit_buf_next[i] = '0;
        res.beeps  = kste_pkg::BEEP_ACK;
      end else if (key.code == kste_pkg::KEY_STAR) begin
        if (count != '0) begin
          count_next                 = count - 1'b1;
          digit_buf_next[count_next] = '0;
        end
        res.beeps = kste_pkg::BEEP_ACK;
      end else if (dig[4]) begin
        // drop the digit when the buffer is full
        if (count < kste_pkg::CNT_W'(kste_pkg::DIGITS)) begin
          digit_buf_next[count] = dig[3:0];
          count_next            = count + 1'b1;
        end
      end else if (key.code == kste_pkg::KEY_D &&
                   count == kste_pkg::CNT_W'(kste_pkg::DIGITS)) begin
        if (time_ok) begin
          res.hours   = hh[kste_pkg::HOURS_W-1:0];
          res.minutes = mm[kste_pkg::MS_W-1:0];
          res.seconds = ss[kste_pkg::MS_W-1:0];
          if (mode == kste_pkg::MODE_TIME) begin
            res.target = kste_pkg::TGT_CLOCK;
          end else begin
            res.target    = kste_pkg::TGT_ALARM;
            alarm_en_next = 1'b1;
          end
          mode_next = kste_pkg::MODE_NORMAL;
          res.beeps = kste_pkg::BEEP_OK;
        end else begin
          res.beeps = kste_pkg::BEEP_BAD;
        end
        count_next = '0;
        for (int i = 0; i < kste_pkg::DIGITS; i++) digit_buf_next[i] = '0;
      end
    end

    res.alarm_on = alarm_en_next;
    res.mode     = kste_pkg::mode_code(mode_next);
    res.count    = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= kste_pkg::MODE_NORMAL;
      count    <= '0;
      alarm_en <= 1'b0;
      for (int i = 0; i < kste_pkg::DIGITS; i++) digit_buf[i] <= '0;
    end else if (step) begin
      mode     <= mode_next;
      count    <= count_next;
      alarm_en <= alarm_en_next;
      for (int i = 0; i < kste_pkg::DIGITS; i++) digit_buf[i] <= digit_buf_next[i];
    end
  end

endmodule
